@@ design/sbs_pkg.sv @@
// shared constants, codes and types of the side-by-side stereo remapper
package sbs_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = $clog2(MAX_DIM) + 1;
    localparam int COORD_W    = 12;
    localparam int PAN_W      = 14;
    localparam int ZOOM_W     = 24;
    localparam int FRAC_W     = 16;
    localparam int MIRROR_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int POS_W      = 22;

    localparam int MIRROR_LEFT  = 0;
    localparam int MIRROR_RIGHT = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUT_WIDTH   = 3'd0,
        CFG_OUT_HEIGHT  = 3'd1,
        CFG_SRC_WIDTH   = 3'd2,
        CFG_SRC_HEIGHT  = 3'd3,
        CFG_PAN_X       = 3'd4,
        CFG_PAN_Y       = 3'd5,
        CFG_ZOOM        = 3'd6,
        CFG_MIRROR_MODE = 3'd7
    } sbs_cfg_idx_t;

    typedef enum logic [1:0] {
        PICK_BLACK = 2'd0,
        PICK_LEFT  = 2'd1,
        PICK_RIGHT = 2'd2
    } sbs_pick_t;

    typedef struct packed {
        logic [DIM_W-1:0]        out_width;
        logic [DIM_W-1:0]        out_height;
        logic [DIM_W-1:0]        src_width;
        logic [DIM_W-1:0]        src_height;
        logic signed [PAN_W-1:0] pan_x;
        logic signed [PAN_W-1:0] pan_y;
        logic [ZOOM_W-1:0]       zoom_q16;
        logic [MIRROR_W-1:0]     mirror_mode;
    } sbs_cfg_t;

    typedef struct packed {
        logic                    busy;
        logic [DIM_W-1:0]        fw;
        logic [DIM_W-1:0]        fh;
        logic [DIM_W-1:0]        sw;
        logic [DIM_W-1:0]        sh;
        logic [DIM_W-2:0]        half;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic [ZOOM_W-1:0]       recip;
    } sbs_geom_t;

endpackage

@@ design/sbs_if.sv @@
// stream interfaces for pixel coordinates and remap results
interface sbs_coord_if import sbs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;

    modport source (output valid, output out_x, output out_y, input ready);
    modport sink (input valid, input out_x, input out_y, output ready);
endinterface

interface sbs_remap_if import sbs_pkg::*; ();
    logic               valid;
    logic               ready;
    sbs_pick_t          source_pick;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;

    modport source (output valid, output source_pick, output src_x, output src_y, input ready);
    modport sink (input valid, input source_pick, input src_x, input src_y, output ready);
endinterface

@@ design/sbs_setup.sv @@
// frame geometry setup: fit zoom, reciprocal and pan offsets over many cycles
module sbs_setup import sbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  sbs_cfg_t  cfg,
    output sbs_geom_t geom
);

    localparam int DIVD_W = 2 * FRAC_W + 1;
    localparam int CNT_W  = $clog2(DIVD_W);
    localparam int ACC_W  = POS_W + FRAC_W + 1;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_LOAD  = 10'b0000000010,
        ST_DIV_A = 10'b0000000100,
        ST_DIV_B = 10'b0000001000,
        ST_FIT   = 10'b0000010000,
        ST_DIV_R = 10'b0000100000,
        ST_MUL_X = 10'b0001000000,
        ST_PAN_X = 10'b0010000000,
        ST_MUL_Y = 10'b0100000000,
        ST_PAN_Y = 10'b1000000000
    } setup_state_t;

    setup_state_t             state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    logic [ZOOM_W-1:0]        div_rem_reg;
    logic [DIVD_W-1:0]        div_quo_reg;
    logic [ZOOM_W-1:0]        div_dsr_reg;
    logic [ZOOM_W-1:0]        a_reg, b_reg, z_reg, r_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]         mcd_reg;
    logic [DIM_W-1:0]         mpl_reg;
    logic signed [POS_W-1:0]  px_reg, py_reg;

    logic [DIM_W-1:0]         sw, sh, fw, fh;
    logic [ZOOM_W-1:0]        zh, z_min, z_fit;
    logic signed [PAN_W-1:0]  p2x, p2y;
    logic signed [ACC_W-1:0]  acc_x_init, acc_y_init, acc_step;
    logic [ZOOM_W:0]          rem_sh;
    logic                     div_ge;
    logic [ZOOM_W:0]          rem_diff;
    logic [ZOOM_W-1:0]        rem_step;
    logic [DIVD_W-1:0]        quo_step;
    logic                     div_last, mul_last;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic lo_one);
        logic [DIM_W-1:0] d;
        d = v;
        if (lo_one && v == '0)
            d = DIM_W'(1);
        if (v > DIM_W'(MAX_DIM))
            d = DIM_W'(MAX_DIM);
        return d;
    endfunction

    function automatic logic [ZOOM_W-1:0] sat_q(input logic [DIVD_W-1:0] q);
        return (|q[DIVD_W-1:ZOOM_W]) ? '1 : q[ZOOM_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] trunc_pos(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] b;
        b = a + (a[ACC_W-1] ? ACC_W'((64'd1 << (FRAC_W + 1)) - 64'd1) : ACC_W'(0));
        return POS_W'(b >>> (FRAC_W + 1));
    endfunction

    function automatic logic signed [PAN_W-1:0] half_pan(input logic signed [PAN_W-1:0] p);
        logic signed [PAN_W-1:0] t;
        t = p + $signed({{(PAN_W-1){1'b0}}, p[PAN_W-1]});
        return t >>> 1;
    endfunction

    // frame and source sizes
    always_comb
    begin
        sw = clamp_dim(cfg.src_width, 1'b1);
        sh = clamp_dim(cfg.src_height, 1'b1);
        if (cfg.out_width == '0 || cfg.out_height == '0)
        begin
            fw = sw;
            fh = sh;
        end
        else
        begin
            fw = clamp_dim(cfg.out_width, 1'b0);
            fh = clamp_dim(cfg.out_height, 1'b0);
        end
    end

    assign zh    = cfg.zoom_q16 >> 1;
    assign z_min = (a_reg < b_reg) ? a_reg : b_reg;
    assign z_fit = (z_min == '0) ? ZOOM_W'(1) : z_min;

    assign p2x = half_pan(cfg.pan_x);
    assign p2y = half_pan(cfg.pan_y);
    assign acc_x_init = (ACC_W'(p2x) <<< (FRAC_W + 1)) + (ACC_W'(fw) <<< (FRAC_W - 1));
    assign acc_y_init = (ACC_W'(p2y) <<< (FRAC_W + 1)) + (ACC_W'(fh) <<< FRAC_W);

    // restoring divider, one quotient bit per cycle
    assign rem_sh   = {div_rem_reg, div_quo_reg[DIVD_W-1]};
    assign div_ge   = rem_sh >= {1'b0, div_dsr_reg};
    assign rem_diff = rem_sh - {1'b0, div_dsr_reg};
    assign rem_step = div_ge ? rem_diff[ZOOM_W-1:0] : rem_sh[ZOOM_W-1:0];
    assign quo_step = {div_quo_reg[DIVD_W-2:0], div_ge};
    assign div_last = cnt_reg == CNT_W'(DIVD_W - 1);

    // shift-and-subtract multiply of source size by zoom
    assign acc_step = mpl_reg[0] ? acc_reg - $signed(mcd_reg) : acc_reg;
    assign mul_last = cnt_reg == CNT_W'(DIM_W - 1);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: ;
            ST_LOAD:
            begin
                cnt_next   = '0;
                state_next = (zh == '0) ? ST_DIV_A : ST_DIV_R;
            end
            ST_DIV_A:
            begin
                cnt_next = div_last ? '0 : cnt_reg + CNT_W'(1);
                if (div_last)
                    state_next = ST_DIV_B;
            end
            ST_DIV_B:
            begin
                cnt_next = div_last ? '0 : cnt_reg + CNT_W'(1);
                if (div_last)
                    state_next = ST_FIT;
            end
            ST_FIT:
                state_next = ST_DIV_R;
            ST_DIV_R:
            begin
                cnt_next = div_last ? '0 : cnt_reg + CNT_W'(1);
                if (div_last)
                    state_next = ST_MUL_X;
            end
            ST_MUL_X:
            begin
                cnt_next = mul_last ? '0 : cnt_reg + CNT_W'(1);
                if (mul_last)
                    state_next = ST_PAN_X;
            end
            ST_PAN_X:
                state_next = ST_MUL_Y;
            ST_MUL_Y:
            begin
                cnt_next = mul_last ? '0 : cnt_reg + CNT_W'(1);
                if (mul_last)
                    state_next = ST_PAN_Y;
            end
            ST_PAN_Y:
                state_next = ST_IDLE;
            default:
                state_next = ST_LOAD;
        endcase
        if (start)
        begin
            state_next = ST_LOAD;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!start)
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    div_rem_reg <= '0;
                    if (zh == '0)
                    begin
                        div_quo_reg <= DIVD_W'(fw) << FRAC_W;
                        div_dsr_reg <= ZOOM_W'(sw) << 1;
                    end
                    else
                    begin
                        z_reg       <= zh;
                        div_quo_reg <= DIVD_W'(1) << (2 * FRAC_W);
                        div_dsr_reg <= zh;
                    end
                end
                ST_DIV_A:
                begin
                    if (div_last)
                    begin
                        a_reg       <= sat_q(quo_step);
                        div_rem_reg <= '0;
                        div_quo_reg <= DIVD_W'(fh) << FRAC_W;
                        div_dsr_reg <= ZOOM_W'(sh);
                    end
                    else
                    begin
                        div_rem_reg <= rem_step;
                        div_quo_reg <= quo_step;
                    end
                end
                ST_DIV_B:
                begin
                    div_rem_reg <= rem_step;
                    div_quo_reg <= quo_step;
                    if (div_last)
                        b_reg <= sat_q(quo_step);
                end
                ST_FIT:
                begin
                    z_reg       <= z_fit;
                    div_rem_reg <= '0;
                    div_quo_reg <= DIVD_W'(1) << (2 * FRAC_W);
                    div_dsr_reg <= z_fit;
                end
                ST_DIV_R:
                begin
                    div_rem_reg <= rem_step;
                    div_quo_reg <= quo_step;
                    if (div_last)
                    begin
                        r_reg   <= sat_q(quo_step);
                        acc_reg <= acc_x_init;
                        mcd_reg <= ACC_W'(z_reg);
                        mpl_reg <= sw;
                    end
                end
                ST_MUL_X, ST_MUL_Y:
                begin
                    acc_reg <= acc_step;
                    mcd_reg <= mcd_reg << 1;
                    mpl_reg <= mpl_reg >> 1;
                end
                ST_PAN_X:
                begin
                    px_reg  <= trunc_pos(acc_reg);
                    acc_reg <= acc_y_init;
                    mcd_reg <= ACC_W'(z_reg);
                    mpl_reg <= sh;
                end
                ST_PAN_Y:
                    py_reg <= trunc_pos(acc_reg);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        geom.busy  = state_reg != ST_IDLE;
        geom.fw    = fw;
        geom.fh    = fh;
        geom.sw    = sw;
        geom.sh    = sh;
        geom.half  = fw[DIM_W-1:1];
        geom.px    = px_reg;
        geom.py    = py_reg;
        geom.recip = r_reg;
    end

    a_busy_ends_after_pan: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(geom.busy) |-> $past(state_reg == ST_PAN_Y))
        else $error("setup finished outside its last step");

    a_idle_has_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (r_reg != '0 && z_reg != '0))
        else $error("zero zoom or reciprocal after setup");

    a_write_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> state_reg == ST_LOAD)
        else $error("register write did not restart setup");

endmodule

@@ design/stereo_side_by_side_remap_top.sv @@
// side-by-side stereo remapper: registers, pixel pipeline and output skid stage
//
// coord channel takes one output pixel (out_x, out_y) per item; remap channel
// returns one item per pixel: source_pick (black, left or right image) with the
// source column and row, both zero for black. items leave in arrival order.
// registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while no item is in flight, the block itself does not enforce
// it. every write, and reset, starts the geometry setup, which runs a shared
// bit-serial divider three times with automatic fit zoom and once with a set
// zoom, and a shift-subtract multiplier twice. coord.ready stays low during
// setup. after setup the pipeline takes one item every cycle while the skid
// register is empty; its depth is set by the split 22x24 bit scale multiply,
// summing and rounding stages.
// when the receiver stalls, a skid register catches the item already on its
// way, then the whole pipeline holds and coord.ready drops; nothing is lost.
// reset clears the registers to their defaults and empties the pipeline.
module stereo_side_by_side_remap_top import sbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    sbs_coord_if.sink             coord,
    sbs_remap_if.source           remap
);

    localparam int MID_W   = DIM_W + 1;
    localparam int SPLIT_W = ZOOM_W / 2;
    localparam int PROD_W  = POS_W + SPLIT_W + 1;
    localparam int SUM_W   = POS_W + ZOOM_W;
    localparam int Q_W     = SUM_W - FRAC_W;

    typedef struct packed {
        logic inframe;
        logic right;
        logic left;
    } flags_t;

    typedef struct packed {
        logic [COORD_W-1:0]      x;
        logic [COORD_W-1:0]      y;
        logic signed [MID_W-1:0] m;
    } s1_t;

    typedef struct packed {
        logic signed [POS_W-1:0] dy;
        logic signed [POS_W-1:0] dl;
        logic signed [POS_W-1:0] dr;
        flags_t                  f;
    } s2_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] yl, yh, ll, lh, rl, rh;
        flags_t                   f;
    } s3_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] y, l, r;
        flags_t                  f;
    } s4_t;

    typedef struct packed {
        logic signed [Q_W-1:0] y, l, r;
        flags_t                f;
    } s5_t;

    typedef struct packed {
        sbs_pick_t          pick;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
    } res_t;

    sbs_cfg_t  cfg_reg;
    sbs_geom_t geom;

    logic adv, accept;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    s4_t  s4_reg, s4_next;
    s5_t  s5_reg, s5_next;
    res_t res_next, out_reg, skid_reg;
    logic out_valid_reg, skid_valid_reg;

    function automatic logic in_range(input logic signed [Q_W-1:0] q,
                                      input logic [DIM_W-1:0] lim);
        return !q[Q_W-1] && (q[Q_W-2:DIM_W] == '0) && (q[DIM_W-1:0] < lim);
    endfunction

    function automatic logic signed [Q_W-1:0] scale_down(input logic signed [SUM_W-1:0] p);
        logic signed [SUM_W-1:0] t;
        t = p + (p[SUM_W-1] ? SUM_W'((64'd1 << FRAC_W) - 64'd1) : SUM_W'(0));
        return Q_W'(t >>> FRAC_W);
    endfunction

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.out_width   <= '0;
            cfg_reg.out_height  <= '0;
            cfg_reg.src_width   <= DIM_W'(1);
            cfg_reg.src_height  <= DIM_W'(1);
            cfg_reg.pan_x       <= '0;
            cfg_reg.pan_y       <= '0;
            cfg_reg.zoom_q16    <= '0;
            cfg_reg.mirror_mode <= '0;
        end
        else if (cfg_we)
        begin
            unique case (sbs_cfg_idx_t'(cfg_index))
                CFG_OUT_WIDTH:   cfg_reg.out_width   <= cfg_data[DIM_W-1:0];
                CFG_OUT_HEIGHT:  cfg_reg.out_height  <= cfg_data[DIM_W-1:0];
                CFG_SRC_WIDTH:   cfg_reg.src_width   <= cfg_data[DIM_W-1:0];
                CFG_SRC_HEIGHT:  cfg_reg.src_height  <= cfg_data[DIM_W-1:0];
                CFG_PAN_X:       cfg_reg.pan_x       <= $signed(cfg_data[PAN_W-1:0]);
                CFG_PAN_Y:       cfg_reg.pan_y       <= $signed(cfg_data[PAN_W-1:0]);
                CFG_ZOOM:        cfg_reg.zoom_q16    <= cfg_data[ZOOM_W-1:0];
                CFG_MIRROR_MODE: cfg_reg.mirror_mode <= cfg_data[MIRROR_W-1:0];
                default: ;
            endcase
        end
    end

    sbs_setup u_setup (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cfg_we),
        .cfg   (cfg_reg),
        .geom  (geom)
    );

    assign adv         = !skid_valid_reg;
    assign coord.ready = adv && !geom.busy;
    assign accept      = coord.valid && coord.ready;

    // stage 1: mirrored column (fw - 2x) / 2, truncated toward zero
    always_comb
    begin
        logic signed [MID_W:0] v;
        v = $signed({2'b00, geom.fw}) - $signed({2'b00, coord.out_x, 1'b0});
        s1_next.x = coord.out_x;
        s1_next.y = coord.out_y;
        s1_next.m = MID_W'((v + $signed({{MID_W{1'b0}}, v[MID_W]})) >>> 1);
    end

    // stage 2: offsets from the pan origin
    always_comb
    begin
        logic signed [POS_W-1:0] xs, hs, ms, cl, cr;
        xs = $signed(POS_W'(s1_reg.x));
        hs = $signed(POS_W'(geom.half));
        ms = POS_W'(s1_reg.m);
        cl = cfg_reg.mirror_mode[MIRROR_LEFT] ? ms : xs;
        cr = cfg_reg.mirror_mode[MIRROR_RIGHT] ? ms + hs : xs - hs;
        s2_next.dy = $signed(POS_W'(s1_reg.y)) - geom.py;
        s2_next.dl = cl - geom.px;
        s2_next.dr = cr - geom.px;
        s2_next.f.inframe = ({1'b0, s1_reg.x} < geom.fw) && ({1'b0, s1_reg.y} < geom.fh);
        s2_next.f.right   = s1_reg.x > geom.half;
        s2_next.f.left    = s1_reg.x < geom.half;
    end

    // stage 3: partial products with the two halves of the reciprocal
    always_comb
    begin
        logic signed [SPLIT_W:0] rlo, rhi;
        rlo = $signed({1'b0, geom.recip[SPLIT_W-1:0]});
        rhi = $signed({1'b0, geom.recip[ZOOM_W-1:SPLIT_W]});
        s3_next.yl = s2_reg.dy * rlo;
        s3_next.yh = s2_reg.dy * rhi;
        s3_next.ll = s2_reg.dl * rlo;
        s3_next.lh = s2_reg.dl * rhi;
        s3_next.rl = s2_reg.dr * rlo;
        s3_next.rh = s2_reg.dr * rhi;
        s3_next.f  = s2_reg.f;
    end

    // stage 4: full products
    always_comb
    begin
        s4_next.y = (SUM_W'(s3_reg.yh) <<< SPLIT_W) + SUM_W'(s3_reg.yl);
        s4_next.l = (SUM_W'(s3_reg.lh) <<< SPLIT_W) + SUM_W'(s3_reg.ll);
        s4_next.r = (SUM_W'(s3_reg.rh) <<< SPLIT_W) + SUM_W'(s3_reg.rl);
        s4_next.f = s3_reg.f;
    end

    // stage 5: drop the fraction, truncating toward zero
    always_comb
    begin
        s5_next.y = scale_down(s4_reg.y);
        s5_next.l = scale_down(s4_reg.l);
        s5_next.r = scale_down(s4_reg.r);
        s5_next.f = s4_reg.f;
    end

    // source choice
    always_comb
    begin
        logic y_ok;
        y_ok = s5_reg.f.inframe && in_range(s5_reg.y, geom.sh);
        res_next.pick = PICK_BLACK;
        res_next.sx   = '0;
        res_next.sy   = '0;
        if (y_ok && s5_reg.f.right && in_range(s5_reg.r, geom.sw))
        begin
            res_next.pick = PICK_RIGHT;
            res_next.sx   = s5_reg.r[COORD_W-1:0];
            res_next.sy   = s5_reg.y[COORD_W-1:0];
        end
        else if (y_ok && s5_reg.f.left && in_range(s5_reg.l, geom.sw))
        begin
            res_next.pick = PICK_LEFT;
            res_next.sx   = s5_reg.l[COORD_W-1:0];
            res_next.sy   = s5_reg.y[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
        end
    end

    // output register with skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (remap.ready)
                skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || remap.ready)
            out_valid_reg <= s5_valid_reg;
        else if (s5_valid_reg)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (remap.ready)
                out_reg <= skid_reg;
        end
        else if (!out_valid_reg || remap.ready)
            out_reg <= res_next;
        else
            skid_reg <= res_next;
    end

    assign remap.valid       = out_valid_reg;
    assign remap.source_pick = out_reg.pick;
    assign remap.src_x       = out_reg.sx;
    assign remap.src_y       = out_reg.sy;

    a_no_input_in_setup: assert property (@(posedge clk) disable iff (!rst_n)
        geom.busy |-> !coord.ready)
        else $error("item taken while geometry setup runs");

    a_black_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (remap.valid && remap.source_pick == PICK_BLACK) |->
            (remap.src_x == '0 && remap.src_y == '0))
        else $error("black item with non-zero source position");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while output register is empty");

    a_skid_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !coord.ready)
        else $error("item taken while pipeline is held");

endmodule
